@@ hdl/dual_pole_stereographic_projection_assert.svh @@
// Assertion macros for the dual-pole stereographic projection block.
// Used by the port checker; needs nothing else.
`ifndef DUAL_POLE_STEREOGRAPHIC_PROJECTION_ASSERT_SVH
`define DUAL_POLE_STEREOGRAPHIC_PROJECTION_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define DPSP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpsp assertion failed");

// Next-cycle implication, off while reset is high
`define DPSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpsp assertion failed");

// Next-cycle implication that also watches reset itself
`define DPSP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dpsp assertion failed");

`endif

@@ hdl/dpsp_pkg.sv @@
// Shared constants, tables, types and helpers of the stereographic projection block.
// Depends on nothing; imported by the top level, dpsp_sincos and dpsp_div.
package dpsp_pkg;

  localparam int ANGLE_FRAC_DEF = 22;
  localparam int COORD_FRAC_DEF = 24;
  localparam int SERIES_TERMS   = 8;

  localparam logic [63:0] HALF_Q30    = 64'h0000_0000_2000_0000;
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam logic [24:0] DEG2RAD_Q30 = 25'd18740330;

  typedef logic [8:0]  divisor_t;
  typedef logic [31:0] recip_t;

  // Series divisors (2k)(2k+1) for sine, (2k-1)(2k) for cosine
  localparam divisor_t SIN_DIV [SERIES_TERMS] = '{
    9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272};
  localparam divisor_t COS_DIV [SERIES_TERMS] = '{
    9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240};

  // floor(2^32 / divisor); quotient estimate is low by at most one
  localparam recip_t SIN_RECIP [SERIES_TERMS] = '{
    32'd715827882, 32'd214748364, 32'd102261126, 32'd59652323,
    32'd39045157, 32'd27531841, 32'd20452225, 32'd15790320};
  localparam recip_t COS_RECIP [SERIES_TERMS] = '{
    32'd2147483648, 32'd357913941, 32'd143165576, 32'd76695844,
    32'd47721858, 32'd32537631, 32'd23598721, 32'd17895697};

  // Control that travels with every pipeline stage
  typedef struct packed {
    logic valid;
    logic tag;
  } pipe_ctl_t;

  // Round a Q60 product to Q30, half up
  function automatic logic [63:0] round_q30(input logic [63:0] p);
    return (p + HALF_Q30) >> 30;
  endfunction

  // Magnitude of a value bounded by 2^30 in size
  function automatic logic [30:0] mag31(input logic signed [31:0] v);
    logic signed [31:0] n;
    n = -v;
    return v[31] ? n[30:0] : v[30:0];
  endfunction

endpackage

@@ hdl/dual_pole_stereographic_projection.sv @@
// Dual-pole stereographic projection of one grid point per item. Takes one item
// per clock when the output side keeps up. From acceptance to the result an item
// passes the angle pipelines (reduction, radian scaling and an 8-term Taylor
// series at four stages per term), the vector products and the 32-bit long
// division at two quotient bits per stage. The whole pipeline advances
// together; when a result is held at the output every stage holds and in_ready
// drops in the same cycle. Outputs are registered.
// Depends on dpsp_pkg, dpsp_sincos and dpsp_div.
module dual_pole_stereographic_projection import dpsp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] lon_deg,
  input  logic signed [31:0] lat_deg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] south_x,
  output logic signed [31:0] south_y,
  output logic signed [31:0] north_x,
  output logic signed [31:0] north_y,
  output logic               use_south,
  output logic               south_saturated,
  output logic               north_saturated
);

  logic      en;
  pipe_ctl_t in_ctl;
  pipe_ctl_t lat_ctl;
  pipe_ctl_t out_ctl;

  // Advance everything unless a result is waiting
  assign en       = !out_ctl.valid || out_ready;
  assign in_ready = en;
  assign in_ctl   = '{valid: in_valid, tag: (lat_deg > 0)};

  logic signed [31:0] slon, clon, slat, clat;

  dpsp_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lon (
    .clk(clk), .rst(rst), .en(en), .ctl_in(in_ctl), .angle(lon_deg),
    .ctl_out(), .sin_val(slon), .cos_val(clon)
  );

  dpsp_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lat (
    .clk(clk), .rst(rst), .en(en), .ctl_in(in_ctl), .angle(lat_deg),
    .ctl_out(lat_ctl), .sin_val(slat), .cos_val(clat)
  );

  // Vector products: magnitudes first
  pipe_ctl_t          v1_ctl;
  logic [61:0]        v1_px, v1_py;
  logic               v1_nx, v1_ny;
  logic signed [31:0] v1_slat;

  always_ff @(posedge clk) begin
    if (rst) v1_ctl <= '0;
    else if (en) v1_ctl <= lat_ctl;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      v1_px   <= 62'(mag31(slon)) * 62'(mag31(clat));
      v1_py   <= 62'(mag31(clon)) * 62'(mag31(clat));
      v1_nx   <= slon[31] ^ clat[31];
      v1_ny   <= clon[31] ^ clat[31];
      v1_slat <= slat;
    end
  end

  // Round, apply sign, form both divisors
  pipe_ctl_t          v2_ctl;
  logic signed [31:0] v2_vx, v2_vy;
  logic [31:0]        v2_dn, v2_ds;
  logic [63:0]        rnd_x, rnd_y;
  logic signed [31:0] px, py;

  assign rnd_x = round_q30(64'(v1_px));
  assign rnd_y = round_q30(64'(v1_py));
  assign px    = $signed(rnd_x[31:0]);
  assign py    = $signed(rnd_y[31:0]);

  always_ff @(posedge clk) begin
    if (rst) v2_ctl <= '0;
    else if (en) v2_ctl <= v1_ctl;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      v2_vx <= v1_nx ? -px : px;
      v2_vy <= v1_ny ? -py : py;
      v2_dn <= ONE_Q30 - v1_slat;
      v2_ds <= ONE_Q30 + v1_slat;
    end
  end

  logic sx_sat, sy_sat, nx_sat, ny_sat;

  dpsp_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_sx (
    .clk(clk), .rst(rst), .en(en), .ctl_in(v2_ctl), .num(v2_vx), .den(v2_ds),
    .ctl_out(out_ctl), .quo(south_x), .sat(sx_sat)
  );

  dpsp_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_sy (
    .clk(clk), .rst(rst), .en(en), .ctl_in(v2_ctl), .num(v2_vy), .den(v2_ds),
    .ctl_out(), .quo(south_y), .sat(sy_sat)
  );

  dpsp_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_nx (
    .clk(clk), .rst(rst), .en(en), .ctl_in(v2_ctl), .num(v2_vx), .den(v2_dn),
    .ctl_out(), .quo(north_x), .sat(nx_sat)
  );

  dpsp_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_ny (
    .clk(clk), .rst(rst), .en(en), .ctl_in(v2_ctl), .num(v2_vy), .den(v2_dn),
    .ctl_out(), .quo(north_y), .sat(ny_sat)
  );

  // Present the item
  assign out_valid       = out_ctl.valid;
  assign use_south       = out_ctl.tag;
  assign south_saturated = sx_sat | sy_sat;
  assign north_saturated = nx_sat | ny_sat;

endmodule

@@ hdl/dpsp_sincos.sv @@
// Pipelined sine and cosine of an angle in fixed point degrees, Q1.30 out.
// Depends on dpsp_pkg for the series tables, control type and helpers.
module dpsp_sincos import dpsp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  pipe_ctl_t          ctl_in,
  input  logic signed [31:0] angle,
  output pipe_ctl_t          ctl_out,
  output logic signed [31:0] sin_val,
  output logic signed [31:0] cos_val
);

  localparam int AW = ((ANGLE_FRAC_BITS + 10 > 33) ? ANGLE_FRAC_BITS + 10 : 33) + 1;
  localparam int RW = ANGLE_FRAC_BITS + 7;
  localparam int R30W = 37;
  localparam logic [AW-1:0] FULL    = AW'(360) << ANGLE_FRAC_BITS;
  localparam logic [AW-1:0] QUARTER = AW'(90) << ANGLE_FRAC_BITS;
  localparam logic [AW-1:0] OFF     = (AW'(1) << 31) % FULL;
  localparam logic [12:0]   MR      = 13'((AW'(1) << 32) / FULL);

  // Stage A: offset angle to unsigned, estimate wrap count
  pipe_ctl_t   a_ctl;
  logic [31:0] a_u;
  logic [44:0] a_prod;
  logic [31:0] u_in;

  assign u_in = {~angle[31], angle[30:0]};

  always_ff @(posedge clk) begin
    if (rst) a_ctl <= '0;
    else if (en) a_ctl <= ctl_in;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_u    <= u_in;
      a_prod <= 45'(u_in) * 45'(MR);
    end
  end

  // Stage B: remainder of the offset angle, one correction
  pipe_ctl_t     b_ctl;
  logic [AW-1:0] b_r;
  logic [AW-1:0] r_est;

  assign r_est = AW'(a_u) - AW'(a_prod[44:32]) * FULL;

  always_ff @(posedge clk) begin
    if (rst) b_ctl <= '0;
    else if (en) b_ctl <= a_ctl;
  end
  always_ff @(posedge clk) begin
    if (en) b_r <= (r_est >= FULL) ? r_est - FULL : r_est;
  end

  // Stage C: remove the offset, wrap into one turn
  pipe_ctl_t     c_ctl;
  logic [AW-1:0] c_r;

  always_ff @(posedge clk) begin
    if (rst) c_ctl <= '0;
    else if (en) c_ctl <= b_ctl;
  end
  always_ff @(posedge clk) begin
    if (en) c_r <= (b_r >= OFF) ? b_r - OFF : b_r + (FULL - OFF);
  end

  // Stage D: split into quadrant and remainder
  pipe_ctl_t     d_ctl;
  logic [1:0]    d_q;
  logic [RW-1:0] d_rem;
  logic [1:0]    q_sel;
  logic [AW-1:0] q_base;

  always_comb begin
    if (c_r >= 3 * QUARTER) begin
      q_sel  = 2'd3;
      q_base = 3 * QUARTER;
    end else if (c_r >= 2 * QUARTER) begin
      q_sel  = 2'd2;
      q_base = 2 * QUARTER;
    end else if (c_r >= QUARTER) begin
      q_sel  = 2'd1;
      q_base = QUARTER;
    end else begin
      q_sel  = 2'd0;
      q_base = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) d_ctl <= '0;
    else if (en) d_ctl <= c_ctl;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_q   <= q_sel;
      d_rem <= RW'(c_r - q_base);
    end
  end

  // Stage E: bring remainder to 30 fraction bits, scale to radians
  logic [R30W-1:0] rem30;

  if (ANGLE_FRAC_BITS >= 30) begin : g_shr
    assign rem30 = R30W'(d_rem >> (ANGLE_FRAC_BITS - 30));
  end else begin : g_shl
    assign rem30 = R30W'(d_rem) << (30 - ANGLE_FRAC_BITS);
  end

  pipe_ctl_t   e_ctl;
  logic [1:0]  e_q;
  logic [61:0] e_prod;

  always_ff @(posedge clk) begin
    if (rst) e_ctl <= '0;
    else if (en) e_ctl <= d_ctl;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e_q    <= d_q;
      e_prod <= 62'(rem30) * 62'(DEG2RAD_Q30);
    end
  end

  // Stage F: round to radians in Q1.30
  pipe_ctl_t   f_ctl;
  logic [1:0]  f_q;
  logic [30:0] f_x;
  logic [63:0] f_round;

  assign f_round = round_q30(64'(e_prod));

  always_ff @(posedge clk) begin
    if (rst) f_ctl <= '0;
    else if (en) f_ctl <= e_ctl;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_q <= e_q;
      f_x <= f_round[30:0];
    end
  end

  // Stage G: square the angle
  pipe_ctl_t   g_ctl;
  logic [1:0]  g_q;
  logic [30:0] g_x;
  logic [61:0] g_xx;

  always_ff @(posedge clk) begin
    if (rst) g_ctl <= '0;
    else if (en) g_ctl <= f_ctl;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g_q  <= f_q;
      g_x  <= f_x;
      g_xx <= 62'(f_x) * 62'(f_x);
    end
  end

  // Series state at each term boundary
  pipe_ctl_t          sr_ctl [SERIES_TERMS+1];
  logic [1:0]         sr_q   [SERIES_TERMS+1];
  logic [31:0]        sr_x2  [SERIES_TERMS+1];
  logic [31:0]        sr_ts  [SERIES_TERMS+1];
  logic [31:0]        sr_tc  [SERIES_TERMS+1];
  logic signed [33:0] sr_ss  [SERIES_TERMS+1];
  logic signed [33:0] sr_sc  [SERIES_TERMS+1];
  logic [63:0]        h_round;

  assign h_round = round_q30(64'(g_xx));

  // Stage H: round the square, seed both series
  always_ff @(posedge clk) begin
    if (rst) sr_ctl[0] <= '0;
    else if (en) sr_ctl[0] <= g_ctl;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sr_q[0]  <= g_q;
      sr_x2[0] <= h_round[31:0];
      sr_ts[0] <= 32'(g_x);
      sr_ss[0] <= $signed(34'(g_x));
      sr_tc[0] <= ONE_Q30;
      sr_sc[0] <= $signed(34'(ONE_Q30));
    end
  end

  // One series term per four stages: multiply, round, reciprocal, correct and add
  for (genvar j = 0; j < SERIES_TERMS; j++) begin : g_term
    localparam bit SUBTRACT = (j % 2 == 0);

    pipe_ctl_t          m1_ctl, m2_ctl, m3_ctl;
    logic [1:0]         m1_q, m2_q, m3_q;
    logic [31:0]        m1_x2, m2_x2, m3_x2;
    logic signed [33:0] m1_ss, m1_sc, m2_ss, m2_sc, m3_ss, m3_sc;
    logic [63:0]        m1_ps, m1_pc;
    logic [31:0]        m2_ts, m2_tc, m3_ts, m3_tc;
    logic [63:0]        m3_ms, m3_mc;
    logic [63:0]        rnd_s, rnd_c;
    logic [31:0]        q0s, q0c, qs, qc;
    logic [40:0]        rs, rc;

    always_ff @(posedge clk) begin
      if (rst) begin
        m1_ctl        <= '0;
        m2_ctl        <= '0;
        m3_ctl        <= '0;
        sr_ctl[j+1]   <= '0;
      end else if (en) begin
        m1_ctl        <= sr_ctl[j];
        m2_ctl        <= m1_ctl;
        m3_ctl        <= m2_ctl;
        sr_ctl[j+1]   <= m3_ctl;
      end
    end

    assign rnd_s = round_q30(m1_ps);
    assign rnd_c = round_q30(m1_pc);

    // Exact truncating divide: estimate from reciprocal, fix a low-by-one
    always_comb begin
      q0s = m3_ms[63:32];
      q0c = m3_mc[63:32];
      rs  = 41'(m3_ts) - 41'(q0s) * 41'(SIN_DIV[j]);
      rc  = 41'(m3_tc) - 41'(q0c) * 41'(COS_DIV[j]);
      qs  = (rs >= 41'(SIN_DIV[j])) ? q0s + 32'd1 : q0s;
      qc  = (rc >= 41'(COS_DIV[j])) ? q0c + 32'd1 : q0c;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m1_q  <= sr_q[j];
        m1_x2 <= sr_x2[j];
        m1_ss <= sr_ss[j];
        m1_sc <= sr_sc[j];
        m1_ps <= 64'(sr_ts[j]) * 64'(sr_x2[j]);
        m1_pc <= 64'(sr_tc[j]) * 64'(sr_x2[j]);

        m2_q  <= m1_q;
        m2_x2 <= m1_x2;
        m2_ss <= m1_ss;
        m2_sc <= m1_sc;
        m2_ts <= rnd_s[31:0];
        m2_tc <= rnd_c[31:0];

        m3_q  <= m2_q;
        m3_x2 <= m2_x2;
        m3_ss <= m2_ss;
        m3_sc <= m2_sc;
        m3_ts <= m2_ts;
        m3_tc <= m2_tc;
        m3_ms <= 64'(m2_ts) * 64'(SIN_RECIP[j]);
        m3_mc <= 64'(m2_tc) * 64'(COS_RECIP[j]);

        sr_q[j+1]  <= m3_q;
        sr_x2[j+1] <= m3_x2;
        sr_ts[j+1] <= qs;
        sr_tc[j+1] <= qc;
        sr_ss[j+1] <= SUBTRACT ? m3_ss - $signed({2'b00, qs}) : m3_ss + $signed({2'b00, qs});
        sr_sc[j+1] <= SUBTRACT ? m3_sc - $signed({2'b00, qc}) : m3_sc + $signed({2'b00, qc});
      end
    end
  end

  // Final stage: clamp to [0, 1], rotate by quadrant
  logic signed [33:0] s_end, c_end;
  logic signed [31:0] cs, cc;

  assign s_end = sr_ss[SERIES_TERMS];
  assign c_end = sr_sc[SERIES_TERMS];

  always_comb begin
    if (s_end < 0) cs = '0;
    else if (s_end > $signed(34'(ONE_Q30))) cs = $signed(ONE_Q30);
    else cs = s_end[31:0];
    if (c_end < 0) cc = '0;
    else if (c_end > $signed(34'(ONE_Q30))) cc = $signed(ONE_Q30);
    else cc = c_end[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) ctl_out <= '0;
    else if (en) ctl_out <= sr_ctl[SERIES_TERMS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      case (sr_q[SERIES_TERMS])
        2'd0: begin
          sin_val <= cs;
          cos_val <= cc;
        end
        2'd1: begin
          sin_val <= cc;
          cos_val <= -cs;
        end
        2'd2: begin
          sin_val <= -cs;
          cos_val <= -cc;
        end
        default: begin
          sin_val <= -cc;
          cos_val <= cs;
        end
      endcase
    end
  end

endmodule

@@ hdl/dpsp_div.sv @@
// Pipelined saturating divide of a Q1.30 coordinate by (1 - z) or (1 + z), result in fixed point.
// Depends on dpsp_pkg for the control type and magnitude helper.
module dpsp_div import dpsp_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  pipe_ctl_t          ctl_in,
  input  logic signed [31:0] num,
  input  logic [31:0]        den,
  output pipe_ctl_t          ctl_out,
  output logic signed [31:0] quo,
  output logic               sat
);

  localparam int NW = ((31 + COORD_FRAC_BITS > 64) ? 31 + COORD_FRAC_BITS : 64) + 2;
  localparam int BITS_PER_STEP = 2;
  localparam int STEPS = 32 / BITS_PER_STEP;

  // Prep: scale magnitude, test for overflow or zero divisor
  logic [30:0]   mag;
  logic          neg;
  logic [NW-1:0] n_full;
  logic [NW-1:0] n_limit;
  logic [NW-1:0] n_top;

  assign mag     = mag31(num);
  assign neg     = num[31];
  assign n_full  = NW'(mag) << COORD_FRAC_BITS;
  assign n_limit = (NW'(den) << 31) + (neg ? NW'(den) : '0);
  assign n_top   = n_full >> 32;

  pipe_ctl_t   st_ctl [STEPS+1];
  logic        st_neg [STEPS+1];
  logic        st_big [STEPS+1];
  logic [32:0] st_rem [STEPS+1];
  logic [31:0] st_low [STEPS+1];
  logic [31:0] st_den [STEPS+1];
  logic [31:0] st_quo [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) st_ctl[0] <= '0;
    else if (en) st_ctl[0] <= ctl_in;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      st_neg[0] <= neg;
      st_big[0] <= (n_full >= n_limit);
      st_rem[0] <= n_top[32:0];
      st_low[0] <= n_full[31:0];
      st_den[0] <= den;
      st_quo[0] <= '0;
    end
  end

  // Long division, two quotient bits per stage
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [32:0] r;
    logic [31:0] lo;
    logic [31:0] qq;

    always_comb begin
      r  = st_rem[s];
      lo = st_low[s];
      qq = st_quo[s];
      for (int b = 0; b < BITS_PER_STEP; b++) begin
        r  = {r[31:0], lo[31]};
        lo = {lo[30:0], 1'b0};
        if (r >= {1'b0, st_den[s]}) begin
          r  = r - {1'b0, st_den[s]};
          qq = {qq[30:0], 1'b1};
        end else begin
          qq = {qq[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) st_ctl[s+1] <= '0;
      else if (en) st_ctl[s+1] <= st_ctl[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_neg[s+1] <= st_neg[s];
        st_big[s+1] <= st_big[s];
        st_rem[s+1] <= r;
        st_low[s+1] <= lo;
        st_den[s+1] <= st_den[s];
        st_quo[s+1] <= qq;
      end
    end
  end

  // Output: apply sign or saturate
  always_ff @(posedge clk) begin
    if (rst) ctl_out <= '0;
    else if (en) ctl_out <= st_ctl[STEPS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sat <= st_big[STEPS];
      if (st_big[STEPS]) quo <= st_neg[STEPS] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else if (st_neg[STEPS]) quo <= -$signed(st_quo[STEPS]);
      else quo <= $signed(st_quo[STEPS]);
    end
  end

endmodule

@@ hdl/dpsp_checker.sv @@
// Port-level checker for the stereographic projection block, bound to the top level.
// Depends on dual_pole_stereographic_projection_assert.svh for its macros.
`include "dual_pole_stereographic_projection_assert.svh"

module dpsp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [31:0] lon_deg,
  input logic signed [31:0] lat_deg,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] south_x,
  input logic signed [31:0] south_y,
  input logic signed [31:0] north_x,
  input logic signed [31:0] north_y,
  input logic               use_south,
  input logic               south_saturated,
  input logic               north_saturated
);

  // A held item stays offered
  `DPSP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // The pipeline takes input exactly when the output can move
  `DPSP_ASSERT_IMPLY(a_ready_tracks_output, clk, rst, 1'b1, in_ready == (!out_valid || out_ready))

  // A stalled result keeps every field and flag
  `DPSP_ASSERT_NEXT(a_result_stable, clk, rst, out_valid && !out_ready, $stable(south_x) && $stable(south_y) && $stable(north_x) && $stable(north_y) && $stable(use_south) && $stable(south_saturated) && $stable(north_saturated))

  // Reset empties the pipeline
  `DPSP_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

endmodule

bind dual_pole_stereographic_projection dpsp_checker u_dpsp_checker (.*);
